[hw/rtl/reader_writer_grant_arbiter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Reader/writer grant arbiter assertion macros
// Shared concurrent assertion forms for the arbiter RTL.
// ----------------------------------------------------------------------------
`ifndef READER_WRITER_GRANT_ARBITER_UNIT_MACROS_SVH
`define READER_WRITER_GRANT_ARBITER_UNIT_MACROS_SVH

// same-cycle implication
`define RWGA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RWGA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rwga_pkg.sv]
// ----------------------------------------------------------------------------
// Reader/writer grant arbiter package
// Shared constants, codes and types of the arbiter.
// ----------------------------------------------------------------------------
package rwga_pkg;

  localparam int ID_BITS      = 8;
  localparam int QUEUE_DEPTH  = 16;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RESULTS  = 16;
  localparam int NCNT_BITS    = $clog2(MAX_RESULTS + 1);
  localparam int READERS_BITS = 9;
  localparam logic [READERS_BITS-1:0] READERS_MAX = '1;
  localparam int KIND_BITS    = 2;

  // command queue between front and back
  localparam int CQ_DEPTH     = 2;
  localparam int CQ_PTR_BITS  = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_BITS  = $clog2(CQ_DEPTH + 1);

  localparam logic CMD_ARRIVE  = 1'b0;
  localparam logic CMD_LEAVE   = 1'b1;
  localparam logic MODE_READER = 1'b0;
  localparam logic MODE_WRITER = 1'b1;

  typedef enum logic [KIND_BITS-1:0] {
    GK_READ    = 2'd0,
    GK_WRITE   = 2'd1,
    GK_REFUSED = 2'd2
  } grant_kind_t;

  typedef enum logic [1:0] {
    EV_ARRIVE_READ,
    EV_ARRIVE_WRITE,
    EV_LEAVE_READ,
    EV_LEAVE_WRITE
  } ev_t;

  typedef struct packed {
    ev_t                ev;
    logic [ID_BITS-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [ID_BITS-1:0] id;
  } idq_ctl_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ_ONE,
    OP_WRITE,
    OP_RELEASE,
    OP_RELEASE_IF
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

[hw/rtl/rwga_front.sv]
// ----------------------------------------------------------------------------
// Arbiter front end
// Accepts event words, decodes them and buffers them for the back end.
// ----------------------------------------------------------------------------
module rwga_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic                         reader,
  input  logic [rwga_pkg::ID_BITS-1:0] requester_id,
  output logic                         cmd_valid,
  output rwga_pkg::cmd_t               cmd,
  input  logic                         cmd_pop
);
  import rwga_pkg::*;

  cmd_t                   slots [CQ_DEPTH];
  logic [CQ_PTR_BITS-1:0] wr_ptr;
  logic [CQ_PTR_BITS-1:0] rd_ptr;
  logic [CQ_CNT_BITS-1:0] fill;
  logic                   accept;
  ev_t                    ev_dec;

  assign in_stall  = (fill == CQ_CNT_BITS'(CQ_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign cmd       = slots[rd_ptr];

  always_comb begin
    case ({command, reader})
      {CMD_ARRIVE, 1'b1}: ev_dec = EV_ARRIVE_READ;
      {CMD_ARRIVE, 1'b0}: ev_dec = EV_ARRIVE_WRITE;
      {CMD_LEAVE, 1'b1}:  ev_dec = EV_LEAVE_READ;
      default:            ev_dec = EV_LEAVE_WRITE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= '{ev: ev_dec, id: requester_id};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({accept, cmd_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/rwga_idq.sv]
// ----------------------------------------------------------------------------
// Arbiter id queue
// Circular FIFO of waiting requester ids with a registered head word.
// ----------------------------------------------------------------------------
module rwga_idq (
  input  logic                           clk,
  input  logic                           rst,
  input  rwga_pkg::idq_ctl_t             ctl,
  output logic [rwga_pkg::ID_BITS-1:0]   head_id,
  output logic [rwga_pkg::QCNT_BITS-1:0] count
);
  import rwga_pkg::*;

  localparam int SUM_BITS = QPTR_BITS + 1;

  logic [ID_BITS-1:0]   mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] head;
  logic [QPTR_BITS-1:0] head_inc;
  logic [QPTR_BITS-1:0] head_next;
  logic [QPTR_BITS-1:0] tail;
  logic [SUM_BITS-1:0]  tail_sum;

  assign tail_sum  = SUM_BITS'(head) + SUM_BITS'(count);
  assign tail      = (tail_sum >= SUM_BITS'(QUEUE_DEPTH))
                   ? QPTR_BITS'(tail_sum - SUM_BITS'(QUEUE_DEPTH))
                   : QPTR_BITS'(tail_sum);
  assign head_inc  = (head == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_next = ctl.pop ? head_inc : head;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= ctl.id;
    end
  end

  // head word tracks the next head; a push into that slot is forwarded
  always_ff @(posedge clk) begin
    if (ctl.push && (tail == head_next)) begin
      head_id <= ctl.id;
    end else begin
      head_id <= mem[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      case ({ctl.push, ctl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/rwga_back.sv]
// ----------------------------------------------------------------------------
// Arbiter back end
// Sequencer that runs one event: queues, lock state and grant output.
// ----------------------------------------------------------------------------
`include "reader_writer_grant_arbiter_unit_macros.svh"

module rwga_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           prio_mode,
  input  logic                           cmd_valid,
  input  rwga_pkg::cmd_t                 cmd,
  output logic                           cmd_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rwga_pkg::KIND_BITS-1:0] grant_kind,
  output logic [rwga_pkg::ID_BITS-1:0]   granted_id,
  output logic                           last
);
  import rwga_pkg::*;

  state_t                  state, state_next;
  op_t                     op1, op1_next;
  op_t                     op2, op2_next;
  logic [NCNT_BITS-1:0]    n, n_next;
  logic [READERS_BITS-1:0] readers, readers_next, readers_inc;
  logic                    write_active, write_active_next;

  idq_ctl_t                rq_ctl, wq_ctl;
  logic [ID_BITS-1:0]      r_head, w_head;
  logic [QCNT_BITS-1:0]    r_count, w_count;
  logic                    r_full, w_full, r_empty, w_empty;

  logic                    out_free;
  logic                    can_write;
  logic                    emit;
  grant_kind_t             emit_kind;
  logic [ID_BITS-1:0]      emit_id;
  logic                    emit_last;

  rwga_idq u_rq (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rq_ctl),
    .head_id (r_head),
    .count   (r_count)
  );

  rwga_idq u_wq (
    .clk     (clk),
    .rst     (rst),
    .ctl     (wq_ctl),
    .head_id (w_head),
    .count   (w_count)
  );

  assign r_full      = (r_count == QCNT_BITS'(QUEUE_DEPTH));
  assign w_full      = (w_count == QCNT_BITS'(QUEUE_DEPTH));
  assign r_empty     = (r_count == '0);
  assign w_empty     = (w_count == '0);
  assign out_free    = !out_valid || !out_stall;
  assign readers_inc = (readers == READERS_MAX) ? readers : readers + 1'b1;
  assign can_write   = !w_empty && !write_active && (readers == '0)
                     && (n < NCNT_BITS'(MAX_RESULTS));

  always_comb begin
    state_next        = state;
    op1_next          = op1;
    op2_next          = op2;
    n_next            = n;
    readers_next      = readers;
    write_active_next = write_active;
    cmd_pop           = 1'b0;
    rq_ctl            = '{push: 1'b0, pop: 1'b0, id: cmd.id};
    wq_ctl            = '{push: 1'b0, pop: 1'b0, id: cmd.id};
    emit              = 1'b0;
    emit_kind         = GK_READ;
    emit_id           = cmd.id;
    emit_last         = 1'b1;

    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop    = 1'b1;
          n_next     = '0;
          op1_next   = OP_NONE;
          op2_next   = OP_NONE;
          state_next = ST_RUN;
          case (cmd.ev)
            EV_ARRIVE_READ: begin
              if (r_full) begin
                emit       = 1'b1;
                emit_kind  = GK_REFUSED;
                state_next = ST_IDLE;
              end else begin
                rq_ctl.push = 1'b1;
                if (!write_active && (prio_mode == MODE_READER || w_empty)) begin
                  op1_next = OP_READ_ONE;
                end
              end
            end
            EV_ARRIVE_WRITE: begin
              if (w_full) begin
                emit       = 1'b1;
                emit_kind  = GK_REFUSED;
                state_next = ST_IDLE;
              end else begin
                wq_ctl.push = 1'b1;
                op1_next    = OP_WRITE;
              end
            end
            EV_LEAVE_READ: begin
              if (readers != '0) begin
                readers_next = readers - 1'b1;
              end
              op1_next = OP_WRITE;
              op2_next = (prio_mode == MODE_WRITER) ? OP_RELEASE_IF : OP_NONE;
            end
            default: begin
              write_active_next = 1'b0;
              if (prio_mode == MODE_READER) begin
                op1_next = OP_RELEASE;
                op2_next = OP_WRITE;
              end else begin
                op1_next = OP_WRITE;
                op2_next = OP_RELEASE_IF;
              end
            end
          endcase
        end
      end

      default: begin
        case (op1)
          OP_READ_ONE: begin
            if (r_empty) begin
              state_next = ST_IDLE;
            end else if (out_free) begin
              emit         = 1'b1;
              emit_kind    = GK_READ;
              emit_id      = r_head;
              rq_ctl.pop   = 1'b1;
              readers_next = readers_inc;
              state_next   = ST_IDLE;
            end
          end
          OP_WRITE: begin
            if (!can_write) begin
              op1_next = op2;
              op2_next = OP_NONE;
            end else if (out_free) begin
              // a granted write blocks any release that follows
              emit              = 1'b1;
              emit_kind         = GK_WRITE;
              emit_id           = w_head;
              wq_ctl.pop        = 1'b1;
              write_active_next = 1'b1;
              state_next        = ST_IDLE;
            end
          end
          OP_RELEASE, OP_RELEASE_IF: begin
            if (r_empty || (n == NCNT_BITS'(MAX_RESULTS))
                || (op1 == OP_RELEASE_IF && write_active)) begin
              op1_next = op2;
              op2_next = OP_NONE;
            end else if (out_free) begin
              // after any read grant a queued write cannot follow
              emit         = 1'b1;
              emit_kind    = GK_READ;
              emit_id      = r_head;
              rq_ctl.pop   = 1'b1;
              readers_next = readers_inc;
              n_next       = n + 1'b1;
              emit_last    = (r_count == QCNT_BITS'(1))
                          || (n == NCNT_BITS'(MAX_RESULTS - 1));
              if (emit_last) begin
                state_next = ST_IDLE;
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op1          <= OP_NONE;
      op2          <= OP_NONE;
      n            <= '0;
      readers      <= '0;
      write_active <= 1'b0;
    end else begin
      state        <= state_next;
      op1          <= op1_next;
      op2          <= op2_next;
      n            <= n_next;
      readers      <= readers_next;
      write_active <= write_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      grant_kind <= emit_kind;
      granted_id <= emit_id;
      last       <= emit_last;
    end
  end

  `RWGA_ASSERT_NOW(a_write_excl, clk, rst, write_active, readers == '0, "write held with readers active")
  `RWGA_ASSERT_NOW(a_write_grant, clk, rst, emit && emit_kind == GK_WRITE, !write_active && readers == '0, "write granted while lock busy")
  `RWGA_ASSERT_NEXT(a_last_ends, clk, rst, emit && emit_last, state == ST_IDLE, "event continues after last word")

endmodule

[hw/rtl/reader_writer_grant_arbiter_unit.sv]
// ----------------------------------------------------------------------------
// Reader/writer grant arbiter
// Readers-writers lock arbiter: queues arrivals and issues grants in order.
// ----------------------------------------------------------------------------
// Input (in_valid/in_stall): one event word of command, reader and
//   requester_id; a two-word command queue takes words while an earlier
//   event runs. Output (out_valid/out_stall): grant_kind, granted_id and
//   last, which marks the final word of an event; an event that neither
//   grants nor refuses gives no word. The user writes priority_mode
//   through cfg_valid/cfg_ready (always ready) only while idle; the block
//   does not enforce this. 0 favors readers, 1 writers. Each event is
//   first decoded (a refusal leaves there), then takes a step for each
//   grant or skipped grant check and a return step if no grant ends it;
//   a reader release burst drains one read grant per cycle while the
//   output is not stalled. Input words pass the command queue first.
// Reset (rst, synchronous): queues empty, no readers, no writer, reader
//   priority. A stalled output word holds; the sequencer waits on it and
//   the input stalls once the command queue fills.
// ----------------------------------------------------------------------------
module reader_writer_grant_arbiter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           priority_mode,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           command,
  input  logic                           reader,
  input  logic [rwga_pkg::ID_BITS-1:0]   requester_id,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rwga_pkg::KIND_BITS-1:0] grant_kind,
  output logic [rwga_pkg::ID_BITS-1:0]   granted_id,
  output logic                           last
);
  import rwga_pkg::*;

  logic prio_mode;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_mode <= MODE_READER;
    end else if (cfg_valid && cfg_ready) begin
      prio_mode <= priority_mode;
    end
  end

  rwga_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .reader       (reader),
    .requester_id (requester_id),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  rwga_back u_back (
    .clk        (clk),
    .rst        (rst),
    .prio_mode  (prio_mode),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .grant_kind (grant_kind),
    .granted_id (granted_id),
    .last       (last)
  );

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// Reader/writer grant arbiter testbench
// Drives arrive and leave events through the input channel and tracks lock
// state in a local predictor. Every grant word out of the block is checked
// against the predictor in order. The run switches priority mode between
// phases, covers full wait queues, release bursts and leaves with nothing
// held, and ends on a cycle limit if the block hangs.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rwga_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic               cmd;
    logic               rd;
    logic [ID_BITS-1:0] id;
  } lock_event_t;

  typedef struct {
    grant_kind_t        kind;
    logic [ID_BITS-1:0] id;
    logic               last;
  } grant_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 priority_mode = MODE_READER;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 command = CMD_ARRIVE;
  logic                 reader = 1'b0;
  logic [ID_BITS-1:0]   requester_id = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_BITS-1:0] grant_kind;
  logic [ID_BITS-1:0]   granted_id;
  logic                 last;

  reader_writer_grant_arbiter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .priority_mode (priority_mode),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .reader        (reader),
    .requester_id  (requester_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .grant_kind    (grant_kind),
    .granted_id    (granted_id),
    .last          (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // events waiting to be sent, grant words still owed by the block
  lock_event_t pend[$];
  grant_word_t grants_due[$];

  // predictor state
  logic                    prio_mode = MODE_READER;
  logic [ID_BITS-1:0]      rd_wait[$];
  logic [ID_BITS-1:0]      wr_wait[$];
  logic [READERS_BITS-1:0] readers_active = '0;
  logic                    writing = 1'b0;
  grant_word_t             ev_words[$];

  int fails = 0;
  int events_taken = 0;
  int words_checked = 0;
  int cycles = 0;

  function automatic void post_word(grant_kind_t kind, logic [ID_BITS-1:0] id);
    if (ev_words.size() >= MAX_RESULTS) return;
    ev_words.push_back('{kind, id, 1'b0});
  endfunction

  function automatic void grant_one_read();
    if (rd_wait.size() == 0 || ev_words.size() >= MAX_RESULTS) return;
    post_word(GK_READ, rd_wait.pop_front());
    if (readers_active != READERS_MAX) readers_active++;
  endfunction

  function automatic void release_readers();
    while (rd_wait.size() != 0 && ev_words.size() < MAX_RESULTS) grant_one_read();
  endfunction

  function automatic void try_write();
    if (wr_wait.size() == 0 || writing || readers_active != 0) return;
    if (ev_words.size() >= MAX_RESULTS) return;
    post_word(GK_WRITE, wr_wait.pop_front());
    writing = 1'b1;
  endfunction

  function automatic void apply_lock_event(lock_event_t ev);
    grant_word_t w;
    ev_words.delete();
    if (ev.cmd == CMD_ARRIVE) begin
      if (ev.rd) begin
        if (rd_wait.size() >= QUEUE_DEPTH) begin
          post_word(GK_REFUSED, ev.id);
        end else begin
          rd_wait.push_back(ev.id);
          if (!writing && (prio_mode == MODE_READER || wr_wait.size() == 0)) grant_one_read();
        end
      end else begin
        if (wr_wait.size() >= QUEUE_DEPTH) begin
          post_word(GK_REFUSED, ev.id);
        end else begin
          wr_wait.push_back(ev.id);
          try_write();
        end
      end
    end else begin
      if (ev.rd) begin
        if (readers_active != 0) readers_active--;
      end else begin
        writing = 1'b0;
      end
      if (prio_mode == MODE_READER) begin
        if (!ev.rd) release_readers();
        try_write();
      end else begin
        try_write();
        if (!writing) release_readers();
      end
    end
    foreach (ev_words[i]) begin
      w = ev_words[i];
      w.last = (i == ev_words.size() - 1);
      grants_due.push_back(w);
    end
  endfunction

  // driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    lock_event_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_lock_event('{command, reader, requester_id});
        events_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend.size() != 0) begin
          nxt = pend.pop_front();
          in_valid <= 1'b1;
          command <= nxt.cmd;
          reader <= nxt.rd;
          requester_id <= nxt.id;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each word taken and drives out_stall in a randomly chosen style
  int stall_left = 0;
  int stall_style = 0;
  int style_age = 0;
  always @(posedge clk) begin
    grant_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (grants_due.size() == 0) begin
          $error("unexpected grant word: kind %0d id %0d last %0d",
                 grant_kind, granted_id, last);
          fails++;
        end else begin
          want = grants_due.pop_front();
          if (grant_kind !== want.kind) begin
            $error("grant_kind: expected %0d, got %0d", want.kind, grant_kind);
            fails++;
          end
          if (granted_id !== want.id) begin
            $error("granted_id: expected %0d, got %0d", want.id, granted_id);
            fails++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            fails++;
          end
        end
      end
      if (style_age == 0) begin
        style_age = $urandom_range(50, 300);
        stall_style = $urandom_range(0, 2);
      end
      style_age--;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: begin
            if ($urandom_range(0, 9) == 0) begin
              stall_left = $urandom_range(1, 7);
              out_stall <= 1'b1;
            end else begin
              out_stall <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void add_event(logic cmd, logic rd, int id);
    pend.push_back('{cmd, rd, id[ID_BITS-1:0]});
  endfunction

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    priority_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    prio_mode = m;
    cfg_valid <= 1'b0;
  endtask

  // block holds a small command queue, so let it drain after the last grant
  task automatic settle();
    while (pend.size() != 0 || in_valid || grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random traffic in episodes: balanced, flooding (full queues) or draining
  task automatic queue_traffic(int n);
    int w_ar, w_aw, w_lr, pick, left;
    w_ar = 0;
    w_aw = 0;
    w_lr = 0;
    left = 0;
    repeat (n) begin
      if (left == 0) begin
        left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0: begin w_ar = 35; w_aw = 20; w_lr = 30; end
          1: begin w_ar = 45; w_aw = 35; w_lr = 10; end
          default: begin w_ar = 15; w_aw = 10; w_lr = 45; end
        endcase
      end
      left--;
      pick = $urandom_range(0, 99);
      if (pick < w_ar) add_event(CMD_ARRIVE, 1'b1, $urandom_range(0, 255));
      else if (pick < w_ar + w_aw) add_event(CMD_ARRIVE, 1'b0, $urandom_range(0, 255));
      else if (pick < w_ar + w_aw + w_lr) add_event(CMD_LEAVE, 1'b1, $urandom_range(0, 255));
      else add_event(CMD_LEAVE, 1'b0, $urandom_range(0, 255));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_mode(MODE_READER);
    // leaves with nothing held, then a full reader queue behind a writer
    add_event(CMD_LEAVE, 1'b1, 8'h00);
    add_event(CMD_LEAVE, 1'b0, 8'hFF);
    add_event(CMD_ARRIVE, 1'b0, 8'h00);
    add_event(CMD_ARRIVE, 1'b1, 8'hFF);
    for (int i = 1; i < QUEUE_DEPTH; i++) add_event(CMD_ARRIVE, 1'b1, i);
    add_event(CMD_ARRIVE, 1'b1, 8'hAA);
    add_event(CMD_ARRIVE, 1'b0, 8'h80);
    // writer leaves: whole reader queue released in one burst
    add_event(CMD_LEAVE, 1'b0, 8'h00);
    add_event(CMD_LEAVE, 1'b1, 8'h55);
    settle();

    for (int p = 0; p < 5; p++) begin
      write_mode((p % 2 == 0) ? MODE_WRITER : MODE_READER);
      queue_traffic(55);
      settle();
    end

    foreach (grants_due[i]) begin
      $error("grant word never seen: kind %0d id %0d", grants_due[i].kind, grants_due[i].id);
      fails++;
    end
    $display("Sent %0d lock events across reader and writer priority phases,", events_taken);
    $display("checked %0d grant words including full queues and release bursts", words_checked);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
